/* hdl/bstep_pkg.sv */
// Shared types, codes and helpers for the three-axis Bresenham step generator.
package bstep_pkg;

  // Width of one signed count field on the input stream
  localparam int unsigned DELTA_W = 24;
  localparam int unsigned S_TDATA_W = 3 * DELTA_W;
  localparam int unsigned M_TDATA_W = 8;

  // Item kinds carried on s_axis_tuser
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  // One result item before packing onto the output stream
  typedef struct packed {
    logic       done;
    logic       moving;
    logic [2:0] dir;
    logic [2:0] step;
  } result_t;

  // Axis driven by the first error term for a given major axis
  function automatic axis_e minor_a(axis_e major);
    axis_e m;
    unique case (major)
      AXIS_X:  m = AXIS_Y;
      AXIS_Y:  m = AXIS_X;
      AXIS_Z:  m = AXIS_Y;
      default: m = AXIS_Y;
    endcase
    return m;
  endfunction

  // Axis driven by the second error term for a given major axis
  function automatic axis_e minor_b(axis_e major);
    axis_e m;
    unique case (major)
      AXIS_X:  m = AXIS_Z;
      AXIS_Y:  m = AXIS_Z;
      AXIS_Z:  m = AXIS_X;
      default: m = AXIS_Z;
    endcase
    return m;
  endfunction

endpackage

/* hdl/bstep_queue.sv */
// Two-entry register queue between the front end and the step engine.
module bstep_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? ~wptr_q : wptr_q;
    rptr_d = pop_i  ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

/* hdl/bstep_front.sv */
// Input side: takes stream transactions, decodes kind, magnitudes and directions.
module bstep_front
  import bstep_pkg::*;
#(
  parameter int unsigned StepBits = 24,
  parameter int unsigned MagW     = StepBits - 1,
  parameter int unsigned EntryW   = 1 + 3 * MagW + 3
) (
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tuser,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output logic [EntryW-1:0]    q_entry_o
);

  logic [StepBits-1:0] raw   [3];
  logic [StepBits-1:0] neg   [3];
  logic [MagW-1:0]     mag   [3];
  logic [2:0]          dir;

  assign s_axis_tready = ~q_full_i;
  assign q_push_o      = s_axis_tvalid & ~q_full_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      // Keep the low StepBits of the field, zero above the field width
      raw[k] = StepBits'(s_axis_tdata[k*DELTA_W +: DELTA_W]);
      neg[k] = ~raw[k] + StepBits'(1);
      if (raw[k][StepBits-1]) begin
        // Saturate the most negative count
        mag[k] = neg[k][StepBits-1] ? {MagW{1'b1}} : neg[k][MagW-1:0];
      end else begin
        mag[k] = raw[k][MagW-1:0];
      end
      dir[k] = ~raw[k][StepBits-1] & (|raw[k]);
    end
    q_entry_o = {dir, mag[2], mag[1], mag[0], (s_axis_tuser == ACT_TICK)};
  end

endmodule

/* hdl/bstep_back.sv */
// Step engine: runs loads and ticks from the queue and holds the output register.
module bstep_back
  import bstep_pkg::*;
#(
  parameter int unsigned MagW   = 23,
  parameter int unsigned EntryW = 1 + 3 * MagW + 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  logic [EntryW-1:0] q_entry_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output result_t           out_res_o
);

  localparam int unsigned ErrW = MagW + 3;

  logic            is_tick;
  logic [MagW-1:0] mag [3];
  logic [2:0]      ent_dir;
  logic            fire;

  axis_e           ld_axis;
  logic [MagW-1:0] ld_maj, ld_ma, ld_mb;

  axis_e           axis_q, axis_d;
  logic [MagW-1:0] rem_q, rem_d;
  logic [MagW-1:0] maj_q, maj_d;
  logic [MagW-1:0] ma_q, ma_d;
  logic [MagW-1:0] mb_q, mb_d;
  logic [ErrW-1:0] erra_q, erra_d;
  logic [ErrW-1:0] errb_q, errb_d;
  logic [2:0]      dir_q, dir_d;
  logic            busy_q, busy_d;
  logic            oval_q, oval_d;
  result_t         res_q, res_d;

  logic            stepa, stepb, last;
  logic [2:0]      stepv;
  logic [ErrW-1:0] maj2;

  always_comb begin
    is_tick = q_entry_i[0];
    for (int k = 0; k < 3; k++) begin
      mag[k] = q_entry_i[1 + k*MagW +: MagW];
    end
    ent_dir = q_entry_i[1 + 3*MagW +: 3];
    fire    = q_valid_i & (~oval_q | out_ready_i);
    q_pop_o = fire;

    // Dominant axis, ties go to the earlier axis
    if (mag[0] >= mag[1] && mag[0] >= mag[2]) begin
      ld_axis = AXIS_X;
    end else if (mag[1] >= mag[2]) begin
      ld_axis = AXIS_Y;
    end else begin
      ld_axis = AXIS_Z;
    end
    ld_maj = mag[ld_axis];
    ld_ma  = mag[minor_a(ld_axis)];
    ld_mb  = mag[minor_b(ld_axis)];

    stepa = ~erra_q[ErrW-1];
    stepb = ~errb_q[ErrW-1];
    maj2  = ErrW'({maj_q, 1'b0});
    last  = (rem_q == MagW'(1));
    stepv = 3'b000;
    stepv[axis_q] = 1'b1;
    if (stepa) begin
      stepv[minor_a(axis_q)] = 1'b1;
    end
    if (stepb) begin
      stepv[minor_b(axis_q)] = 1'b1;
    end

    axis_d = axis_q;
    rem_d  = rem_q;
    maj_d  = maj_q;
    ma_d   = ma_q;
    mb_d   = mb_q;
    erra_d = erra_q;
    errb_d = errb_q;
    dir_d  = dir_q;
    busy_d = busy_q;
    res_d  = res_q;
    oval_d = oval_q & ~out_ready_i;

    if (fire) begin
      oval_d = 1'b1;
      if (!is_tick) begin
        // Load: drop any move in progress and start the new one
        axis_d = ld_axis;
        rem_d  = ld_maj;
        maj_d  = ld_maj;
        ma_d   = ld_ma;
        mb_d   = ld_mb;
        erra_d = ErrW'({ld_ma, 1'b0}) - ErrW'(ld_maj);
        errb_d = ErrW'({ld_mb, 1'b0}) - ErrW'(ld_maj);
        dir_d  = ent_dir;
        busy_d = (ld_maj != '0);
        res_d  = '{done: 1'b0, moving: (ld_maj != '0), dir: ent_dir, step: 3'b000};
      end else if (busy_q) begin
        erra_d = erra_q + ErrW'({ma_q, 1'b0}) - (stepa ? maj2 : '0);
        errb_d = errb_q + ErrW'({mb_q, 1'b0}) - (stepb ? maj2 : '0);
        rem_d  = rem_q - MagW'(1);
        busy_d = ~last;
        res_d  = '{done: last, moving: ~last, dir: dir_q, step: stepv};
      end else begin
        res_d  = '{done: 1'b0, moving: 1'b0, dir: dir_q, step: 3'b000};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= AXIS_X;
      rem_q  <= '0;
      maj_q  <= '0;
      ma_q   <= '0;
      mb_q   <= '0;
      erra_q <= '0;
      errb_q <= '0;
      dir_q  <= 3'b000;
      busy_q <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      axis_q <= axis_d;
      rem_q  <= rem_d;
      maj_q  <= maj_d;
      ma_q   <= ma_d;
      mb_q   <= mb_d;
      erra_q <= erra_d;
      errb_q <= errb_d;
      dir_q  <= dir_d;
      busy_q <= busy_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = oval_q;
  assign out_res_o   = res_q;

endmodule

/* hdl/three_axis_bresenham_stepper_core.sv */
// Accepted transactions enter the queue; the engine registers each result in the
// output register. One item per cycle while m_axis_tready is high; every tick is one
// add/compare step of the engine. A two-entry queue separates input and engine; the
// output register holds a result while the next items are still taken in.
// Reset (rst_ni low, asynchronous) clears the queue, the output and the move state to idle.
module three_axis_bresenham_stepper_core
  import bstep_pkg::*;
#(
  parameter int unsigned STEP_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // delta_x[23:0], delta_y[47:24], delta_z[71:48]
  input  logic                 s_axis_tuser,  // action
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // step_x, step_y, step_z, dir_x, dir_y, dir_z,
                                              // moving, zero pad
  output logic                 m_axis_tlast   // move_done
);

  localparam int unsigned MagW   = STEP_BITS - 1;
  localparam int unsigned EntryW = 1 + 3 * MagW + 3;

  logic              q_full, q_empty, q_push, q_pop;
  logic [EntryW-1:0] q_wdata, q_rdata;
  result_t           res;

  bstep_front #(
    .StepBits (STEP_BITS),
    .MagW     (MagW),
    .EntryW   (EntryW)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (q_wdata)
  );

  bstep_queue #(
    .Width (EntryW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_rdata)
  );

  bstep_back #(
    .MagW   (MagW),
    .EntryW (EntryW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (~q_empty),
    .q_entry_i   (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {1'b0, res.moving, res.dir, res.step};
  assign m_axis_tlast = res.done;

endmodule

/* hdl/bstep_checker.sv */
// Port-level checks on the result stream, bound to the top level.
module bstep_checker
  import bstep_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tlast
);

  // Hold a stalled result
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // The final step of a move ends it and always steps at least one axis
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[6] && (m_axis_tdata[2:0] != 3'b000))
    else $error("move end without a step or still moving");

  // Any step that is not the last of a move leaves the move running
  a_step_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast && (m_axis_tdata[2:0] != 3'b000) |-> m_axis_tdata[6])
    else $error("step issued outside a move");

endmodule

bind three_axis_bresenham_stepper_core bstep_checker u_bstep_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
